FILE: src/pbd_pkg.sv
// ============================================================================
// pbd_pkg
// Shared types and constants for the PCI base address register decoder.
// ============================================================================
package pbd_pkg;

    // Default slot limit of a device header
    localparam int MAX_BARS_DEF = 6;

    // Low type bits of a base address register (bits 2..0)
    localparam logic [2:0] TYPE_MEM32   = 3'd0;
    localparam logic [2:0] TYPE_IO      = 3'd1;
    localparam logic [2:0] TYPE_MEM20   = 3'd2;
    localparam logic [2:0] TYPE_MEM64   = 3'd4;
    localparam logic [2:0] TYPE_IO_HIGH = 3'd5;

    // Address range codes
    localparam logic [6:0] RANGE_NONE = 7'd0;
    localparam logic [6:0] RANGE_20   = 7'd20;
    localparam logic [6:0] RANGE_32   = 7'd32;
    localparam logic [6:0] RANGE_64   = 7'd64;

    // Low bits cleared from a base: port or memory layout
    localparam logic [31:0] PORT_LOW_MASK = 32'h0000_0003;
    localparam logic [31:0] MEM_LOW_MASK  = 32'h0000_000f;

    // Flag bit positions in the type table
    localparam int FLAG_MEM_BIT  = 0;
    localparam int FLAG_PORT_BIT = 1;
    localparam int FLAG_PREF_BIT = 2;

    // Flags by bits 3..0 of the register: {pref, port, mem}
    localparam logic [2:0] TYPE_FLAGS [16] = '{
        3'b001, 3'b010, 3'b001, 3'b000,
        3'b001, 3'b010, 3'b000, 3'b000,
        3'b101, 3'b010, 3'b101, 3'b000,
        3'b101, 3'b010, 3'b000, 3'b000
    };

    typedef struct packed {
        logic [31:0] bar_value;
        logic [31:0] probe_value;
        logic        last_slot;
    } t_slot_in;

    typedef struct packed {
        logic        entry_valid;
        logic [31:0] base_addr;
        logic        is_memory;
        logic        is_port;
        logic        prefetchable;
        logic [4:0]  size_log2;
        logic [6:0]  range_log2;
        logic        upper_half;
    } t_slot_out;

    // Clear the low flag bits: two for port registers, four for memory
    function automatic logic [31:0] masked_base(input logic [31:0] v);
        logic [31:0] low;
        low = v[0] ? PORT_LOW_MASK : MEM_LOW_MASK;
        return v & ~low;
    endfunction

endpackage

FILE: src/pbd_if.sv
// ============================================================================
// pbd_in_if / pbd_out_if
// Valid/ready channels carrying slot items into and results out of the block.
// ============================================================================
interface pbd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] bar_value;
    logic [31:0] probe_value;
    logic        last_slot;

    modport source (output valid, output bar_value, output probe_value,
                    output last_slot, input ready);
    modport sink   (input valid, input bar_value, input probe_value,
                    input last_slot, output ready);
endinterface

interface pbd_out_if;
    logic        valid;
    logic        ready;
    logic        entry_valid;
    logic [31:0] base_addr;
    logic        is_memory;
    logic        is_port;
    logic        prefetchable;
    logic [4:0]  size_log2;
    logic [6:0]  range_log2;
    logic        upper_half;

    modport source (output valid, output entry_valid, output base_addr,
                    output is_memory, output is_port, output prefetchable,
                    output size_log2, output range_log2, output upper_half,
                    input ready);
    modport sink   (input valid, input entry_valid, input base_addr,
                    input is_memory, input is_port, input prefetchable,
                    input size_log2, input range_log2, input upper_half,
                    output ready);
endinterface

FILE: src/pbd_ctz.sv
// ============================================================================
// pbd_ctz
// Trailing-zero count of a 32-bit word; zero input gives zero.
// ============================================================================
module pbd_ctz (
    input  logic [31:0] i_value,
    output logic [4:0]  o_count
);

    // Priority encode from the top so the lowest set bit wins
    always_comb begin
        o_count = 5'd0;
        for (int i = 31; i >= 0; i--) begin
            if (i_value[i]) begin
                o_count = 5'(i);
            end
        end
    end

endmodule

FILE: src/pbd_core.sv
// ============================================================================
// pbd_core
// Per-slot decode and the running list state (upper half, end, slot count).
// ============================================================================
module pbd_core #(
    parameter int MAX_BARS = pbd_pkg::MAX_BARS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  pbd_pkg::t_slot_in  i_slot,
    output pbd_pkg::t_slot_out o_result
);

    localparam int SLOT_W = $clog2(MAX_BARS + 1);
    localparam logic [SLOT_W-1:0] SLOT_LIMIT = SLOT_W'(MAX_BARS);

    logic              r_upper_pending, n_upper_pending;
    logic              r_list_ended,    n_list_ended;
    logic [SLOT_W-1:0] r_slot_index,    n_slot_index;

    logic [31:0] probe_masked;
    logic [4:0]  probe_tz;
    logic [6:0]  range_code;
    logic [2:0]  flags;
    logic        in_list;

    assign probe_masked = pbd_pkg::masked_base(i_slot.probe_value);

    pbd_ctz u_ctz (
        .i_value (probe_masked),
        .o_count (probe_tz)
    );

    always_comb begin
        case (i_slot.bar_value[2:0])
            pbd_pkg::TYPE_MEM32:   range_code = pbd_pkg::RANGE_32;
            pbd_pkg::TYPE_IO:      range_code = pbd_pkg::RANGE_32;
            pbd_pkg::TYPE_IO_HIGH: range_code = pbd_pkg::RANGE_32;
            pbd_pkg::TYPE_MEM20:   range_code = pbd_pkg::RANGE_20;
            pbd_pkg::TYPE_MEM64:   range_code = pbd_pkg::RANGE_64;
            default:               range_code = pbd_pkg::RANGE_NONE;
        endcase
    end

    assign flags   = pbd_pkg::TYPE_FLAGS[i_slot.bar_value[3:0]];
    assign in_list = !r_list_ended && (r_slot_index < SLOT_LIMIT);

    always_comb begin
        o_result        = '0;
        n_upper_pending = r_upper_pending;
        n_list_ended    = r_list_ended;
        n_slot_index    = r_slot_index;

        if (in_list) begin
            if (r_upper_pending) begin
                // upper word of a 64-bit register: raw pass-through
                o_result.entry_valid = 1'b1;
                o_result.base_addr   = i_slot.bar_value;
                o_result.upper_half  = 1'b1;
                n_upper_pending      = 1'b0;
            end else if (i_slot.bar_value == 32'd0 || range_code == pbd_pkg::RANGE_NONE) begin
                n_list_ended = 1'b1;
            end else begin
                o_result.entry_valid  = 1'b1;
                o_result.base_addr    = pbd_pkg::masked_base(i_slot.bar_value);
                o_result.is_memory    = flags[pbd_pkg::FLAG_MEM_BIT];
                o_result.is_port      = flags[pbd_pkg::FLAG_PORT_BIT];
                o_result.prefetchable = flags[pbd_pkg::FLAG_PREF_BIT];
                o_result.size_log2    = probe_tz;
                o_result.range_log2   = range_code;
                n_upper_pending       = (range_code == pbd_pkg::RANGE_64);
            end
        end

        if (r_slot_index < SLOT_LIMIT) begin
            n_slot_index = r_slot_index + 1'b1;
        end

        // last slot of the device: back to a fresh list
        if (i_slot.last_slot) begin
            n_upper_pending = 1'b0;
            n_list_ended    = 1'b0;
            n_slot_index    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_pending <= 1'b0;
            r_list_ended    <= 1'b0;
            r_slot_index    <= '0;
        end else if (i_step) begin
            r_upper_pending <= n_upper_pending;
            r_list_ended    <= n_list_ended;
            r_slot_index    <= n_slot_index;
        end
    end

endmodule

FILE: src/pci_bar_decoder.sv
// ============================================================================
// pci_bar_decoder
// Decodes a device's base address registers one item per cycle when unstalled.
// ============================================================================
// Feed the slots of one device in order, each item holding the original
// register value and the all-ones readback, with last_slot set on the final
// slot. Every accepted item yields exactly one result item, in order. The
// block takes a new item every cycle while the output is not stalled. An
// accepted item is held in the input register while it is decoded, and its
// result is then registered in the result register and offered from there.
// The single decode stage between the two registers does the mask, the
// type-table lookup and a 32-bit trailing-zero count. Stalls on the output
// side back up through the two registers without losing or repeating items.
// ============================================================================
module pci_bar_decoder #(
    parameter int MAX_BARS = pbd_pkg::MAX_BARS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pbd_in_if.sink    i_in,
    pbd_out_if.source o_out
);

    // Input register stage
    logic              r_s1_valid, n_s1_valid;
    pbd_pkg::t_slot_in r_s1;

    // Result register stage
    logic               r_out_valid, n_out_valid;
    pbd_pkg::t_slot_out r_out;
    pbd_pkg::t_slot_out dec_result;

    logic out_free;   // result register can take a new item this cycle
    logic s1_fire;    // decode stage hands its item on
    logic in_fire;

    assign out_free = !r_out_valid || o_out.ready;
    assign s1_fire  = r_s1_valid && out_free;
    assign in_fire  = i_in.valid && i_in.ready;

    // Accept while the input register is empty or draining this cycle
    assign i_in.ready = !r_s1_valid || out_free;

    // Decode logic and running list state; state advances once per item
    pbd_core #(
        .MAX_BARS (MAX_BARS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s1_fire),
        .i_slot   (r_s1),
        .o_result (dec_result)
    );

    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_out_valid = r_out_valid;
        if (in_fire) begin
            n_s1_valid = 1'b1;
        end else if (s1_fire) begin
            n_s1_valid = 1'b0;
        end
        if (s1_fire) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1.bar_value   <= i_in.bar_value;
            r_s1.probe_value <= i_in.probe_value;
            r_s1.last_slot   <= i_in.last_slot;
        end
        if (s1_fire) begin
            r_out <= dec_result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.entry_valid  = r_out.entry_valid;
    assign o_out.base_addr    = r_out.base_addr;
    assign o_out.is_memory    = r_out.is_memory;
    assign o_out.is_port      = r_out.is_port;
    assign o_out.prefetchable = r_out.prefetchable;
    assign o_out.size_log2    = r_out.size_log2;
    assign o_out.range_log2   = r_out.range_log2;
    assign o_out.upper_half   = r_out.upper_half;

endmodule
